### design/qs_pkg.sv
`default_nettype none
package qs_pkg;

  // number format of the quaternion components
  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = 31;
  localparam int DIV_STEPS    = 61;
  localparam int QDEPTH       = 2;

  // dot product rescale to Q30
  localparam int C_SH_R = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int C_SH_L = (2 * FRAC_BITS >= 30) ? 0 : 30 - 2 * FRAC_BITS;

  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] CORDIC_K    = 36'sd652032874;

  typedef logic signed [15:0] comp_t;

  // one classified request handed from front to back
  typedef struct packed {
    comp_t [3:0] p;
    comp_t [3:0] q;
    logic [15:0] t;
    logic        fail;
    logic        neg;
    logic [29:0] c;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_CHK, ST_VEC, ST_PT, ST_SINI, ST_SIN,
    ST_DIVI, ST_DIV, ST_MUL0, ST_MUL1, ST_ACC, ST_DONE
  } qs_state_e;

  // truncated Q30 arctangent table
  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic signed [35:0] v;
    case (i)
      5'd0:  v = 36'sd843314856;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043836;
      5'd3:  v = 36'sd133525158;
      5'd4:  v = 36'sd67021686;
      5'd5:  v = 36'sd33543515;
      5'd6:  v = 36'sd16775850;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194282;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048575;
      5'd11: v = 36'sd524287;
      5'd12: v = 36'sd262143;
      5'd13: v = 36'sd131071;
      5'd14: v = 36'sd65535;
      5'd15: v = 36'sd32767;
      5'd16: v = 36'sd16383;
      5'd17: v = 36'sd8191;
      5'd18: v = 36'sd4095;
      5'd19: v = 36'sd2047;
      5'd20: v = 36'sd1023;
      5'd21: v = 36'sd511;
      5'd22: v = 36'sd255;
      5'd23: v = 36'sd127;
      5'd24: v = 36'sd63;
      5'd25: v = 36'sd31;
      5'd26: v = 36'sd15;
      5'd27: v = 36'sd8;
      default: v = 36'sd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### design/qs_if.sv
`default_nettype none
// request channel: two quaternions and the fraction
interface qs_req_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] first_w, first_x, first_y, first_z;
  logic signed [15:0] second_w, second_x, second_y, second_z;
  logic [15:0] interp_fraction;
  modport source(output valid, first_w, first_x, first_y, first_z,
                 second_w, second_x, second_y, second_z, interp_fraction,
                 input ready);
  modport sink(input valid, first_w, first_x, first_y, first_z,
               second_w, second_x, second_y, second_z, interp_fraction,
               output ready);
endinterface

// result channel
interface qs_rsp_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] result_w, result_x, result_y, result_z;
  logic        success;
  logic        midpoint_used;
  modport source(output valid, result_w, result_x, result_y, result_z,
                 success, midpoint_used, input ready);
  modport sink(input valid, result_w, result_x, result_y, result_z,
               success, midpoint_used, output ready);
endinterface

// configuration write channel
interface qs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

### design/qs_front.sv
`default_nettype none
module qs_front import qs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qs_req_if.sink    req,
  output entry_t    entry_o,
  output logic      push_o,
  input  wire logic full_i
);

  logic               vld_q, vld_d;
  comp_t [3:0]        p_q, q_q;
  logic [15:0]        t_q;
  logic signed [31:0] prod_q [4];
  logic               take;
  logic signed [33:0] dot;
  logic [33:0]        mag;
  logic [63:0]        cw;

  assign req.ready = !vld_q || !full_i;
  assign take      = req.valid && req.ready;
  assign push_o    = vld_q && !full_i;

  always_comb begin
    vld_d = vld_q;
    if (push_o) vld_d = 1'b0;
    if (take) vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // capture operands and the four products
  always_ff @(posedge clk_i) begin
    if (take) begin
      p_q       <= {req.first_z, req.first_y, req.first_x, req.first_w};
      q_q       <= {req.second_z, req.second_y, req.second_x, req.second_w};
      t_q       <= (req.interp_fraction > 16'd32768) ? 16'd32768 : req.interp_fraction;
      prod_q[0] <= req.first_w * req.second_w;
      prod_q[1] <= req.first_x * req.second_x;
      prod_q[2] <= req.first_y * req.second_y;
      prod_q[3] <= req.first_z * req.second_z;
    end
  end

  // dot product, failure test, Q30 magnitude
  always_comb begin
    dot = 34'(prod_q[0]) + 34'(prod_q[1]) + 34'(prod_q[2]) + 34'(prod_q[3]);
    mag = dot[33] ? 34'(-dot) : 34'(dot);
    cw  = ({30'd0, mag} >> C_SH_R) << C_SH_L;
    entry_o.p    = p_q;
    entry_o.q    = q_q;
    entry_o.t    = t_q;
    entry_o.fail = {30'd0, mag} >= (64'd1 << (2 * FRAC_BITS));
    entry_o.neg  = dot[33];
    entry_o.c    = cw[29:0];
  end

endmodule
`default_nettype wire

### design/qs_fifo.sv
`default_nettype none
module qs_fifo import qs_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t data_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      data_o
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  entry_t          mem_q [QDEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;

  assign full_o  = cnt_q == (AW+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];

  // pointers wrap at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule
`default_nettype wire

### design/qs_back.sv
`default_nettype none
module qs_back import qs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire entry_t      entry_i,
  output logic             pop_o,
  input  wire logic [15:0] limit_i,
  qs_rsp_if.source         rsp
);

  qs_state_e          state_q, state_d;
  entry_t             e_q;
  logic [5:0]         k_q;
  logic [60:0]        rem_q, root_q, bit_q;
  logic signed [35:0] x_q, y_q, z_q;
  logic               vec_q, sel_q;
  logic [31:0]        a_q, pt_q;
  logic [30:0]        sin0_q, sin1_q;
  logic [60:0]        num_q, quo_q;
  logic [31:0]        drem_q;
  logic [45:0]        w0_q, w1_q;
  logic signed [63:0] acc_q, prod_q;
  comp_t [3:0]        r_q;
  logic               succ_q, mid_q;
  logic               out_vld_q;
  logic               load;

  logic               last_cordic, last_sqrt, last_div;
  logic [60:0]        trial;
  logic signed [35:0] xs, ys, at, ynew, xnew, znew;
  logic               dir;
  logic [31:0]        a_cl, th0, th;
  logic [47:0]        apt;
  logic [31:0]        dsh;
  logic signed [63:0] sum, shr;
  logic [30:0]        s_val;
  logic [59:0]        csq;

  assign last_cordic = k_q == 6'(CORDIC_STEPS - 1);
  assign last_sqrt   = k_q == 6'(SQRT_STEPS - 1);
  assign last_div    = k_q == 6'(DIV_STEPS - 1);
  assign s_val       = root_q[30:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (valid_i) state_d = entry_i.fail ? ST_DONE : ST_SQ;
      ST_SQ:   state_d = ST_SQRT;
      ST_SQRT: if (last_sqrt) state_d = ST_CHK;
      ST_CHK:  state_d = (s_val < {1'b0, limit_i, 14'd0}) ? ST_DONE : ST_VEC;
      ST_VEC:  if (last_cordic) state_d = ST_PT;
      ST_PT:   state_d = ST_SINI;
      ST_SINI: state_d = ST_SIN;
      ST_SIN:  if (last_cordic) state_d = sel_q ? ST_DIVI : ST_SINI;
      ST_DIVI: state_d = ST_DIV;
      ST_DIV:  if (last_div) state_d = sel_q ? ST_MUL0 : ST_DIVI;
      ST_MUL0: state_d = ST_MUL1;
      ST_MUL1: state_d = ST_ACC;
      ST_ACC:  state_d = (k_q[1:0] == 2'd3) ? ST_DONE : ST_MUL0;
      ST_DONE: if (load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o = (state_q == ST_IDLE) && valid_i;
    load  = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);
  end

  // shared datapath pieces
  always_comb begin
    csq   = e_q.c * e_q.c;
    trial = root_q + bit_q;
    xs    = x_q >>> k_q;
    ys    = y_q >>> k_q;
    at    = atan_q30(k_q[4:0]);
    dir   = vec_q ? !y_q[35] : !z_q[35];
    if (vec_q) begin
      xnew = dir ? x_q + ys : x_q - ys;
      ynew = dir ? y_q - xs : y_q + xs;
      znew = dir ? z_q + at : z_q - at;
    end else begin
      xnew = dir ? x_q - ys : x_q + ys;
      ynew = dir ? y_q + xs : y_q - xs;
      znew = dir ? z_q - at : z_q + at;
    end
    a_cl = z_q[35] ? 32'd0 : (z_q > PI_Q30) ? PI_Q30[31:0] : z_q[31:0];
    apt  = a_cl * e_q.t;
    th0  = sel_q ? pt_q : a_q - pt_q;
    th   = (th0 > HALF_PI_Q30[31:0]) ? PI_Q30[31:0] - th0 : th0;
    dsh  = {drem_q[30:0], num_q[60]};
    sum  = acc_q + prod_q + 64'sd536870912;
    shr  = sum >>> 30;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) out_vld_q <= 1'b1;
      else if (rsp.ready) out_vld_q <= 1'b0;
    end
  end

  // sequenced datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        e_q    <= entry_i;
        r_q    <= entry_i.p;
        succ_q <= 1'b0;
        mid_q  <= 1'b0;
      end
      ST_SQ: begin
        rem_q  <= (61'd1 << 60) - 61'(csq);
        root_q <= '0;
        bit_q  <= 61'd1 << 60;
        k_q    <= '0;
      end
      ST_SQRT: begin
        if (rem_q >= trial) begin
          rem_q  <= rem_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
        k_q   <= k_q + 1'b1;
      end
      ST_CHK: begin
        succ_q <= 1'b1;
        vec_q  <= 1'b1;
        k_q    <= '0;
        if (s_val < {1'b0, limit_i, 14'd0}) mid_q <= 1'b1;
        for (int i = 0; i < 4; i++) begin
          r_q[i] <= 16'((17'($signed(e_q.p[i])) + 17'($signed(e_q.q[i]))) >>> 1);
        end
        if (e_q.neg) begin
          x_q <= $signed({5'd0, s_val});
          y_q <= $signed({6'd0, e_q.c});
          z_q <= HALF_PI_Q30;
        end else begin
          x_q <= $signed({6'd0, e_q.c});
          y_q <= $signed({5'd0, s_val});
          z_q <= '0;
        end
      end
      ST_VEC, ST_SIN: begin
        x_q <= xnew;
        y_q <= ynew;
        z_q <= znew;
        k_q <= k_q + 1'b1;
        if (state_q == ST_SIN && last_cordic) begin
          if (sel_q) sin1_q <= ynew[35] ? '0 : (ynew > ONE_Q30) ? ONE_Q30[30:0] : ynew[30:0];
          else       sin0_q <= ynew[35] ? '0 : (ynew > ONE_Q30) ? ONE_Q30[30:0] : ynew[30:0];
          sel_q <= !sel_q;
        end
      end
      ST_PT: begin
        a_q   <= a_cl;
        pt_q  <= apt[46:15];
        sel_q <= 1'b0;
      end
      ST_SINI: begin
        vec_q <= 1'b0;
        x_q   <= CORDIC_K;
        y_q   <= '0;
        z_q   <= $signed({4'd0, th});
        k_q   <= '0;
      end
      ST_DIVI: begin
        num_q  <= {(sel_q ? sin1_q : sin0_q), 30'd0};
        drem_q <= '0;
        quo_q  <= '0;
        k_q    <= '0;
      end
      ST_DIV: begin
        num_q <= num_q << 1;
        k_q   <= last_div ? 6'd0 : k_q + 1'b1;
        if (dsh >= {1'b0, s_val}) begin
          drem_q <= dsh - {1'b0, s_val};
          quo_q  <= {quo_q[59:0], 1'b1};
        end else begin
          drem_q <= dsh;
          quo_q  <= {quo_q[59:0], 1'b0};
        end
        if (last_div) begin
          if (sel_q) w1_q <= {quo_q[44:0], dsh >= {1'b0, s_val}};
          else       w0_q <= {quo_q[44:0], dsh >= {1'b0, s_val}};
          sel_q <= !sel_q;
        end
      end
      ST_MUL0: prod_q <= $signed(e_q.p[k_q[1:0]]) * $signed({1'b0, w0_q});
      ST_MUL1: begin
        acc_q  <= prod_q;
        prod_q <= $signed(e_q.q[k_q[1:0]]) * $signed({1'b0, w1_q});
      end
      ST_ACC: begin
        r_q[k_q[1:0]] <= (shr > 64'sd32767) ? 16'sh7fff :
                         (shr < -64'sd32768) ? 16'sh8000 : shr[15:0];
        k_q <= k_q + 1'b1;
      end
      default: ;
    endcase
  end

  // result register, parts the back from the consumer
  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp.result_w      <= r_q[0];
      rsp.result_x      <= r_q[1];
      rsp.result_y      <= r_q[2];
      rsp.result_z      <= r_q[3];
      rsp.success       <= succ_q;
      rsp.midpoint_used <= mid_q;
    end
  end

  assign rsp.valid = out_vld_q;

endmodule
`default_nettype wire

### design/quaternion_slerp.sv
// channel  | dir | handshake     | payload
// req_i    | in  | valid/ready   | first_w..z, second_w..z, interp_fraction
// rsp_o    | out | valid/ready   | result_w..z, success, midpoint_used
// cfg_i    | in  | valid/ready   | data = near_zero_limit (ready always high)
//
// The front takes a request every cycle while the two-entry queue has room.
// The back sequencer runs square root, angle CORDIC, two sine CORDIC passes,
// two bit-serial divides and four component steps, one item at a time, and
// takes the next item once its result is loaded; a failed dot test goes
// straight to the result, the midpoint case right after the square root check.
// Reset is asynchronous and active low; all queues and the result empty.
// The result register holds while rsp_o.ready is low; the front keeps accepting.
`default_nettype none
module quaternion_slerp import qs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  qs_req_if.sink    req_i,
  qs_rsp_if.source  rsp_o,
  qs_cfg_if.sink    cfg_i
);

  entry_t      f_entry, q_entry;
  logic        push, full, pop, q_valid;
  logic [15:0] limit_q;

  // limit register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 16'd7;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.data;
    end
  end

  qs_front u_front (
    .clk_i, .rst_ni, .req(req_i), .entry_o(f_entry), .push_o(push), .full_i(full)
  );

  qs_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_entry), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .data_o(q_entry)
  );

  qs_back u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .entry_i(q_entry), .pop_o(pop),
    .limit_i(limit_q), .rsp(rsp_o)
  );

endmodule
`default_nettype wire

### design/qs_checker.sv
`default_nettype none
module qs_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic [15:0] rsp_w,
  input wire logic rsp_success,
  input wire logic rsp_mid
);

  // result stays offered until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");

  // stalled result holds its payload
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> $stable(rsp_w)) else $error("result changed");

  // midpoint only on a successful result
  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_mid |-> rsp_success) else $error("midpoint without success");

  // no result right after reset
  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid) else $error("result right after reset");

endmodule

bind quaternion_slerp qs_checker u_qs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .rsp_valid(rsp_o.valid), .rsp_ready(rsp_o.ready),
  .rsp_w(rsp_o.result_w), .rsp_success(rsp_o.success), .rsp_mid(rsp_o.midpoint_used)
);
`default_nettype wire

### test/tb_ifs.sv
// Interfaces come from the design folder; this file only adds the testbench types.
package tb_slerp_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  // expected result of one request
  typedef struct {
    logic signed [15:0] r [4];
    logic               ok;
    logic               mid;
  } slerp_res_t;

  // one pending request
  typedef struct {
    logic signed [15:0] p [4];
    logic signed [15:0] q [4];
    logic [15:0]        t;
  } slerp_req_t;
endpackage

### test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import qs_pkg::*;
  import tb_slerp_pkg::*;

  localparam logic signed [63:0] ONE30 = 64'sd1073741824;
  localparam logic signed [63:0] PI30  = 64'sd3373259426;
  localparam logic signed [63:0] HPI30 = 64'sd1686629713;
  localparam logic signed [63:0] K30   = 64'sd652032874;

  logic clk_i = 0;
  logic rst_ni = 0;

  qs_req_if req();
  qs_rsp_if rsp();
  qs_cfg_if cfg();

  quaternion_slerp dut(.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp),
                       .cfg_i(cfg));

  initial forever #5 clk_i = ~clk_i;

  slerp_req_t pending_q[$];
  slerp_res_t expected_q[$];
  logic [15:0] limit_reg = 16'd7;
  int errors = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 80;
  bit cfg_pend = 0;
  logic [15:0] cfg_word = '0;
  bit req_took = 0;

  function automatic logic signed [63:0] floor_shr(logic signed [63:0] v, int n);
    return v >>> n;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // CORDIC vectoring: angle of (x, y), Q30
  function automatic logic signed [63:0] vec_angle(logic signed [63:0] x,
                                                   logic signed [63:0] y);
    logic signed [63:0] z, xs, ys;
    z = 0;
    for (int i = 0; i < 28; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += 64'(atan_q30(5'(i)));
      end else begin
        x -= ys; y += xs; z -= 64'(atan_q30(5'(i)));
      end
    end
    return z;
  endfunction

  // CORDIC rotation sine on [0, pi]
  function automatic logic signed [63:0] sin_q30(logic signed [63:0] th);
    logic signed [63:0] x, y, xs, ys;
    x = K30;
    y = 0;
    if (th < 0) th = 0;
    if (th > PI30) th = PI30;
    if (th > HPI30) th = PI30 - th;
    for (int i = 0; i < 28; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (th >= 0) begin
        x -= ys; y += xs; th -= 64'(atan_q30(5'(i)));
      end else begin
        x += ys; y -= xs; th += 64'(atan_q30(5'(i)));
      end
    end
    if (y < 0) y = 0;
    if (y > ONE30) y = ONE30;
    return y;
  endfunction

  function automatic slerp_res_t predict_slerp(slerp_req_t it, logic [15:0] lim);
    slerp_res_t res;
    logic signed [63:0] dot, a, pt, w0, w1, acc, v;
    logic [63:0] mag, c, s, t;
    dot = 0;
    for (int i = 0; i < 4; i++) dot += 64'(it.p[i]) * 64'(it.q[i]);
    t = (it.t > 16'd32768) ? 64'd32768 : 64'(it.t);
    mag = (dot < 0) ? -dot : dot;
    res.ok = 1;
    res.mid = 0;
    if (mag >= (64'd1 << 28)) begin
      res.ok = 0;
      for (int i = 0; i < 4; i++) res.r[i] = it.p[i];
    end else begin
      c = mag << 2;
      s = int_sqrt((64'd1 << 60) - c * c);
      if (s < (64'(lim) << 14)) begin
        res.mid = 1;
        for (int i = 0; i < 4; i++) begin
          v = 64'(it.p[i]) + 64'(it.q[i]);
          res.r[i] = 16'(v >>> 1);
        end
      end else begin
        if (dot >= 0) a = vec_angle(c, s);
        else a = HPI30 + vec_angle(s, c);
        if (a < 0) a = 0;
        if (a > PI30) a = PI30;
        pt = (a * t) >> 15;
        w0 = (sin_q30(a - pt) << 30) / s;
        w1 = (sin_q30(pt) << 30) / s;
        for (int i = 0; i < 4; i++) begin
          acc = 64'(it.p[i]) * w0 + 64'(it.q[i]) * w1;
          v = (acc + (64'sd1 << 29)) >>> 30;
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          res.r[i] = 16'(v);
        end
      end
    end
    return res;
  endfunction

  // random quaternion in Q2.14: mode 0 full range, 1 within +-8000, else within +-200
  function automatic void rand_quat(output logic signed [15:0] o [4], input int mode);
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0: o[i] = 16'($urandom);
        1: o[i] = 16'($signed($urandom_range(16000)) - 8000);
        default: o[i] = 16'($signed($urandom_range(400)) - 200);
      endcase
    end
  endfunction

  task automatic push_req(logic signed [15:0] p [4], logic signed [15:0] q [4],
                          logic [15:0] t);
    slerp_req_t it;
    it.p = p;
    it.q = q;
    it.t = t;
    pending_q.push_back(it);
  endtask

  // request handshake as seen at the rising edge
  always @(posedge clk_i) begin
    req_took <= rst_ni && req.valid && req.ready;
  end

  // request, response-ready and configuration driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_took) begin
        expected_q.push_back(predict_slerp(pending_q.pop_front(), limit_reg));
      end
      if ((!req.valid || req_took) && pending_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        req.valid <= 1;
        req.first_w <= pending_q[0].p[0];
        req.first_x <= pending_q[0].p[1];
        req.first_y <= pending_q[0].p[2];
        req.first_z <= pending_q[0].p[3];
        req.second_w <= pending_q[0].q[0];
        req.second_x <= pending_q[0].q[1];
        req.second_y <= pending_q[0].q[2];
        req.second_z <= pending_q[0].q[3];
        req.interp_fraction <= pending_q[0].t;
      end else if (req_took || !req.valid) begin
        req.valid <= 0;
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (cfg.valid && cfg.ready) begin
        limit_reg <= cfg.data;
        cfg_pend <= 0;
        cfg.valid <= 0;
      end else if (cfg_pend) begin
        cfg.valid <= 1;
        cfg.data <= cfg_word;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        slerp_res_t e;
        e = expected_q.pop_front();
        if (rsp.result_w !== e.r[0]) begin
          $error("result_w exp %0d got %0d", e.r[0], rsp.result_w); errors++;
        end
        if (rsp.result_x !== e.r[1]) begin
          $error("result_x exp %0d got %0d", e.r[1], rsp.result_x); errors++;
        end
        if (rsp.result_y !== e.r[2]) begin
          $error("result_y exp %0d got %0d", e.r[2], rsp.result_y); errors++;
        end
        if (rsp.result_z !== e.r[3]) begin
          $error("result_z exp %0d got %0d", e.r[3], rsp.result_z); errors++;
        end
        if (rsp.success !== e.ok) begin
          $error("success exp %0d got %0d", e.ok, rsp.success); errors++;
        end
        if (rsp.midpoint_used !== e.mid) begin
          $error("midpoint_used exp %0d got %0d", e.mid, rsp.midpoint_used); errors++;
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || req.valid || expected_q.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_word = v;
    cfg_pend = 1;
    while (cfg_pend) @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    logic signed [15:0] p [4], q [4];
    int m;
    for (int k = 0; k < n; k++) begin
      m = $urandom_range(9);
      if (m < 1) rand_quat(p, 0);
      else rand_quat(p, 1);
      if (m == 2) q = p;
      else if (m == 3) begin
        for (int i = 0; i < 4; i++) q[i] = -p[i];
      end else if (m < 1) rand_quat(q, 0);
      else begin
        rand_quat(q, 2);
        for (int i = 0; i < 4; i++) q[i] = p[i] + q[i];
        if (m == 4) for (int i = 0; i < 4; i++) q[i] = (p[i] >>> 1) + q[i];
      end
      push_req(p, q, ($urandom_range(9) == 0) ? 16'($urandom) :
               16'($urandom_range(32768)));
    end
  endtask

  initial begin
    logic signed [15:0] p [4], q [4];
    req.valid = 0;
    req.first_w = 0; req.first_x = 0; req.first_y = 0; req.first_z = 0;
    req.second_w = 0; req.second_x = 0; req.second_y = 0; req.second_z = 0;
    req.interp_fraction = 0;
    rsp.ready = 0;
    cfg.valid = 0;
    cfg.data = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: identity pair, orthogonal, opposite, extremes, midpoint
    p = '{16384, 0, 0, 0}; q = '{0, 16384, 0, 0};
    push_req(p, q, 16'd0); push_req(p, q, 16'd32768); push_req(p, q, 16'd16384);
    push_req(p, q, 16'hFFFF);
    q = '{16384, 0, 0, 0};
    push_req(p, q, 16'd16384);
    q = '{-16384, 0, 0, 0};
    push_req(p, q, 16'd16384);
    p = '{-32768, -32768, -32768, -32768}; q = p;
    push_req(p, q, 16'd100);
    p = '{32767, 32767, 32767, 32767}; q = '{-32768, 0, 0, 0};
    push_req(p, q, 16'd8000);
    p = '{11585, 11585, 0, 0}; q = '{11585, -11585, 0, 0};
    push_req(p, q, 16'd1);
    q = '{11580, 11590, 0, 0};
    push_req(p, q, 16'd20000);
    p = '{-16384, 0, 0, 0}; q = '{0, 0, 0, -16384};
    push_req(p, q, 16'd32767);
    q = '{-11585, 0, 0, 11585};
    push_req(p, q, 16'd5000);
    p = '{16384, 0, 0, 0}; q = '{16383, 1, 0, 0};
    push_req(p, q, 16'd16384);
    q = '{-16383, 3, 0, 0};
    push_req(p, q, 16'd16384);
    drain();
    repeat (300) @(posedge clk_i);

    write_limit(16'd65535);
    push_req(p, q, 16'd16384);
    p = '{11585, 11585, 0, 0}; q = '{0, 16384, 0, 0};
    push_req(p, q, 16'd16384);
    random_phase(200);
    drain();
    repeat (300) @(posedge clk_i);

    write_limit(16'd0);
    random_phase(300);
    drain();
    repeat (300) @(posedge clk_i);

    write_limit(16'd7);
    send_idle_pct = 80;
    recv_idle_pct = 37;
    random_phase(500);
    drain();
    repeat (300) @(posedge clk_i);

    write_limit(16'd2000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(600);
    drain();
    repeat (300) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
